>>> sv/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg
// Types, character codes and the per-character phase step of the decimal
// number syntax checker.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam int CH_W    = 8;
    localparam int FIELD_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PARSE_STEPS = 4;

    localparam logic [CH_W-1:0] NUL_CH   = 8'h00;
    localparam logic [CH_W-1:0] SPACE_CH = 8'h20;
    localparam logic [CH_W-1:0] TAB_CH   = 8'h09;
    localparam logic [CH_W-1:0] PLUS_CH  = 8'h2B;
    localparam logic [CH_W-1:0] MINUS_CH = 8'h2D;
    localparam logic [CH_W-1:0] POINT_CH = 8'h2E;
    localparam logic [CH_W-1:0] ZERO_CH  = 8'h30;
    localparam logic [CH_W-1:0] NINE_CH  = 8'h39;
    localparam logic [CH_W-1:0] LC_E_CH  = 8'h65;
    localparam logic [CH_W-1:0] UC_E_CH  = 8'h45;
    localparam logic [CH_W-1:0] LC_D_CH  = 8'h64;
    localparam logic [CH_W-1:0] UC_D_CH  = 8'h44;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALLOW_EXPONENT = 1'b0,
        CFG_START_OFFSET   = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_SIGN      = 3'd1,
        PH_INT       = 3'd2,
        PH_AFTER_INT = 3'd3,
        PH_FRAC      = 3'd4,
        PH_EXP_SIGN  = 3'd5,
        PH_EXP_DIG   = 3'd6,
        PH_TRAIL     = 3'd7
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   int_dig;
        logic   frac_dig;
        logic   fail;
    } step_t;

    typedef struct packed {
        logic               is_numeric;
        logic [FIELD_W-1:0] fail_offset;
        logic [FIELD_W-1:0] integral_digits;
        logic [FIELD_W-1:0] fractional_digits;
        logic [FIELD_W-1:0] significant_digits;
    } result_t;

    function automatic logic is_dig(logic [CH_W-1:0] c);
        return (c >= ZERO_CH) && (c <= NINE_CH);
    endfunction

    function automatic logic is_ws(logic [CH_W-1:0] c);
        return (c == SPACE_CH) || (c == TAB_CH);
    endfunction

    function automatic logic is_sign(logic [CH_W-1:0] c);
        return (c == PLUS_CH) || (c == MINUS_CH);
    endfunction

    function automatic logic is_exp(logic [CH_W-1:0] c);
        return (c == LC_E_CH) || (c == UC_E_CH) || (c == LC_D_CH) || (c == UC_D_CH);
    endfunction

    // Phases that do not take the character fall through to the next one;
    // the longest such chain is lead -> sign -> int -> after_int.
    function automatic step_t parse_step(phase_t ph, logic [CH_W-1:0] c, logic allow);
        step_t s;
        logic  done;
        s.phase    = ph;
        s.int_dig  = 1'b0;
        s.frac_dig = 1'b0;
        s.fail     = 1'b0;
        done       = 1'b0;
        for (int i = 0; i < PARSE_STEPS; i++) begin
            if (!done && !s.fail) begin
                case (s.phase)
                    PH_LEAD:
                    begin
                        if (is_ws(c)) done = 1'b1;
                        else          s.phase = PH_SIGN;
                    end
                    PH_SIGN:
                    begin
                        s.phase = PH_INT;
                        done    = is_sign(c);
                    end
                    PH_INT:
                    begin
                        if (is_dig(c))
                        begin
                            s.int_dig = 1'b1;
                            done      = 1'b1;
                        end
                        else
                        begin
                            s.phase = PH_AFTER_INT;
                        end
                    end
                    PH_AFTER_INT:
                    begin
                        if (c == POINT_CH)
                        begin
                            s.phase = PH_FRAC;
                            done    = 1'b1;
                        end
                        else if (is_exp(c) && allow)
                        begin
                            s.phase = PH_EXP_SIGN;
                            done    = 1'b1;
                        end
                        else
                        begin
                            s.fail = 1'b1;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_dig(c))
                        begin
                            s.frac_dig = 1'b1;
                            done       = 1'b1;
                        end
                        else if (is_exp(c) && allow)
                        begin
                            s.phase = PH_EXP_SIGN;
                            done    = 1'b1;
                        end
                        else if (is_ws(c))
                        begin
                            s.phase = PH_TRAIL;
                            done    = 1'b1;
                        end
                        else
                        begin
                            s.fail = 1'b1;
                        end
                    end
                    PH_EXP_SIGN:
                    begin
                        s.phase = PH_EXP_DIG;
                        done    = is_sign(c);
                    end
                    PH_EXP_DIG:
                    begin
                        if (is_dig(c))
                        begin
                            done = 1'b1;
                        end
                        else if (is_ws(c))
                        begin
                            s.phase = PH_TRAIL;
                            done    = 1'b1;
                        end
                        else
                        begin
                            s.fail = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_ws(c)) done = 1'b1;
                        else          s.fail = 1'b1;
                    end
                endcase
            end
        end
        return s;
    endfunction

endpackage

>>> sv/nsv_if.sv
// ----------------------------------------------------------------------------
// nsv_if
// Valid/ready channels: character words in, verdict words out.
// ----------------------------------------------------------------------------
interface nsv_char_if
    import nsv_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface nsv_verdict_if
    import nsv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               is_numeric;
    logic [FIELD_W-1:0] fail_offset;
    logic [FIELD_W-1:0] integral_digits;
    logic [FIELD_W-1:0] fractional_digits;
    logic [FIELD_W-1:0] significant_digits;

    modport source (output valid, output is_numeric, output fail_offset,
                    output integral_digits, output fractional_digits,
                    output significant_digits, input ready);
    modport sink   (input valid, input is_numeric, input fail_offset,
                    input integral_digits, input fractional_digits,
                    input significant_digits, output ready);
endinterface

>>> sv/nsv_core.sv
// ----------------------------------------------------------------------------
// nsv_core
// Per-string parse state: phase, position, digit counters and failure mark.
// Advances by one character when step is high; a terminator clears it.
// ----------------------------------------------------------------------------
module nsv_core
    import nsv_pkg::*;
#(
    parameter longint unsigned COUNT_MAX = 65535
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [CH_W-1:0]    ch,
    input  logic               allow_exponent,
    input  logic [CFG_W-1:0]   start_offset,
    output result_t            res
);

    localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(COUNT_MAX);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] position_reg, position_next;
    logic             seen_digit_reg, seen_digit_next;
    logic             seen_nonzero_reg, seen_nonzero_next;
    logic             has_failed_reg, has_failed_next;
    logic [CNT_W-1:0] fail_pos_reg, fail_pos_next;
    logic [CNT_W-1:0] int_cnt_reg, int_cnt_next;
    logic [CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic [CNT_W-1:0] sig_cnt_reg, sig_cnt_next;

    step_t st;
    logic  parse_en;
    logic  nonzero;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(logic [CNT_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_W-1:0];
    endfunction

    assign st       = parse_step(phase_reg, ch, allow_exponent);
    assign parse_en = (64'(position_reg) >= 64'(start_offset)) && !has_failed_reg;
    assign nonzero  = seen_nonzero_reg || (ch != ZERO_CH);

    always_comb
    begin
        phase_next        = phase_reg;
        position_next     = position_reg;
        seen_digit_next   = seen_digit_reg;
        seen_nonzero_next = seen_nonzero_reg;
        has_failed_next   = has_failed_reg;
        fail_pos_next     = fail_pos_reg;
        int_cnt_next      = int_cnt_reg;
        frac_cnt_next     = frac_cnt_reg;
        sig_cnt_next      = sig_cnt_reg;
        if (step)
        begin
            if (ch == NUL_CH)
            begin
                phase_next        = PH_LEAD;
                position_next     = '0;
                seen_digit_next   = 1'b0;
                seen_nonzero_next = 1'b0;
                has_failed_next   = 1'b0;
                fail_pos_next     = '0;
                int_cnt_next      = '0;
                frac_cnt_next     = '0;
                sig_cnt_next      = '0;
            end
            else
            begin
                position_next = sat_inc(position_reg);
                if (parse_en)
                begin
                    phase_next = st.phase;
                    if (is_dig(ch))
                        seen_digit_next = 1'b1;
                    if (st.int_dig)
                        int_cnt_next = sat_inc(int_cnt_reg);
                    if (st.frac_dig)
                        frac_cnt_next = sat_inc(frac_cnt_reg);
                    if (st.int_dig || st.frac_dig)
                    begin
                        seen_nonzero_next = nonzero;
                        if (nonzero)
                            sig_cnt_next = sat_inc(sig_cnt_reg);
                    end
                    if (st.fail)
                    begin
                        has_failed_next = 1'b1;
                        fail_pos_next   = position_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEAD;
            position_reg     <= '0;
            seen_digit_reg   <= 1'b0;
            seen_nonzero_reg <= 1'b0;
            has_failed_reg   <= 1'b0;
            fail_pos_reg     <= '0;
            int_cnt_reg      <= '0;
            frac_cnt_reg     <= '0;
            sig_cnt_reg      <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            seen_digit_reg   <= seen_digit_next;
            seen_nonzero_reg <= seen_nonzero_next;
            has_failed_reg   <= has_failed_next;
            fail_pos_reg     <= fail_pos_next;
            int_cnt_reg      <= int_cnt_next;
            frac_cnt_reg     <= frac_cnt_next;
            sig_cnt_reg      <= sig_cnt_next;
        end
    end

    assign res.is_numeric         = !has_failed_reg && seen_digit_reg;
    assign res.fail_offset        = has_failed_reg ? to_field(fail_pos_reg) : '0;
    assign res.integral_digits    = to_field(int_cnt_reg);
    assign res.fractional_digits  = to_field(frac_cnt_reg);
    assign res.significant_digits = to_field(sig_cnt_reg);

endmodule

>>> sv/numeric_string_validator.sv
// ----------------------------------------------------------------------------
// numeric_string_validator
// Checks a zero-terminated character string against decimal number syntax.
// ----------------------------------------------------------------------------
// chars: one character word per handshake; a zero word ends the string.
// verdict: one word per string, sent for the terminator: is_numeric, first
//   failing position and integer, fraction and significant digit counts.
// cfg: write port; allow_exponent (index 0), start_offset (index 1).
//   Characters before start_offset are skipped. Write only while idle.
// Throughput: one character per cycle unless a terminator waits on a pending
//   verdict; the phase step is combinational from the input register to the
//   parse state registers, from which the output register takes the verdict.
// Reset: parse state cleared, allow_exponent = 1, start_offset = 0, no
//   verdict pending.
// Stall: while a verdict waits, ordinary characters keep flowing; a second
//   terminator waits in the input register and chars.ready drops until the
//   verdict is taken.
// ----------------------------------------------------------------------------
module numeric_string_validator
    import nsv_pkg::*;
#(
    parameter longint unsigned COUNT_MAX = 65535
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    nsv_char_if.sink             chars,
    nsv_verdict_if.source        verdict,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic             allow_exp_reg, allow_exp_next;
    logic [CFG_W-1:0] start_off_reg, start_off_next;

    logic             in_valid_reg, in_valid_next;
    logic [CH_W-1:0]  in_ch_reg, in_ch_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;

    logic             in_term;
    logic             in_move;
    result_t          core_res;

    always_comb
    begin
        allow_exp_next = allow_exp_reg;
        start_off_next = start_off_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ALLOW_EXPONENT: allow_exp_next = cfg_wdata[0];
                CFG_START_OFFSET:   start_off_next = cfg_wdata;
                default:            ;
            endcase
        end
    end

    assign in_term      = (in_ch_reg == NUL_CH);
    assign in_move      = in_valid_reg && (!in_term || !out_valid_reg || verdict.ready);
    assign chars.ready  = !in_valid_reg || in_move;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_ch_next     = in_ch_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (chars.ready)
        begin
            in_valid_next = chars.valid;
            in_ch_next    = chars.ch;
        end
        if (verdict.ready)
            out_valid_next = 1'b0;
        if (in_move && in_term)
        begin
            out_valid_next = 1'b1;
            out_res_next   = core_res;
        end
    end

    nsv_core #(
        .COUNT_MAX (COUNT_MAX)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_move),
        .ch             (in_ch_reg),
        .allow_exponent (allow_exp_reg),
        .start_offset   (start_off_reg),
        .res            (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_exp_reg <= 1'b1;
            start_off_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            allow_exp_reg <= allow_exp_next;
            start_off_reg <= start_off_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_ch_reg   <= in_ch_next;
        out_res_reg <= out_res_next;
    end

    assign verdict.valid              = out_valid_reg;
    assign verdict.is_numeric         = out_res_reg.is_numeric;
    assign verdict.fail_offset        = out_res_reg.fail_offset;
    assign verdict.integral_digits    = out_res_reg.integral_digits;
    assign verdict.fractional_digits  = out_res_reg.fractional_digits;
    assign verdict.significant_digits = out_res_reg.significant_digits;

endmodule

>>> sv/nsv_checker.sv
// ----------------------------------------------------------------------------
// nsv_checker
// Port-level checks on the validator, bound to the top level.
// ----------------------------------------------------------------------------
module nsv_checker
    import nsv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               is_numeric,
    input logic [FIELD_W-1:0] fail_offset,
    input logic [FIELD_W-1:0] integral_digits,
    input logic [FIELD_W-1:0] significant_digits
);

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_numeric)
            && $stable(fail_offset) && $stable(integral_digits)
            && $stable(significant_digits))
        else $error("verdict changed while stalled");

    a_numeric_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_numeric |-> fail_offset == '0)
        else $error("numeric verdict carries a fail offset");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind numeric_string_validator nsv_checker u_nsv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (chars.ready),
    .out_valid          (verdict.valid),
    .out_ready          (verdict.ready),
    .is_numeric         (verdict.is_numeric),
    .fail_offset        (verdict.fail_offset),
    .integral_digits    (verdict.integral_digits),
    .significant_digits (verdict.significant_digits)
);
